// File: hw/rtl/stereo_peak_meter_with_decay_core_macros.svh
// Assertion macros for the stereo peak meter core.
// Used by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef STEREO_PEAK_METER_WITH_DECAY_CORE_MACROS_SVH
`define STEREO_PEAK_METER_WITH_DECAY_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SPMD_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spmd: check failed");
`define SPMD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spmd: check failed");
`else
`define SPMD_ASSERT(label, ante, cons)
`define SPMD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: hw/rtl/spmd_pkg.sv
// Shared constants and the log2 fraction table for the peak meter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package spmd_pkg;

    localparam int DEF_RING_DEPTH = 8192;

    localparam int SAMPLE_W = 18;
    localparam int PEAK_W   = 18;
    localparam int LEVEL_W  = 16;
    localparam int BAR_W    = 5;
    localparam int HOLD_W   = 5;
    localparam int SR_W     = 17;
    localparam int WIN_W    = 13;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [SR_W-1:0]    SR_DEFAULT  = 17'd44100;
    // sr/20 = (sr>>2)/5, the /5 by reciprocal 2^18/5 rounded up
    localparam logic [15:0]        DIV5_MUL    = 16'd52429;
    localparam int                 DIV5_SHIFT  = 18;

    localparam logic [HOLD_W-1:0]  HOLD_FRAMES = 5'd20;
    localparam logic [LEVEL_W-1:0] DECAY_Q16   = 16'd1966;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 16'd65535;
    localparam logic [13:0]        LOG_COEF    = 14'd9864;
    localparam logic [PEAK_W-1:0]  FULL_SCALE  = 18'd65536;
    localparam logic [PEAK_W-1:0]  FLOOR_PEAK  = 18'd655;
    localparam logic [BAR_W-1:0]   BAR_MIN     = 5'd5;
    localparam logic [BAR_W-1:0]   BAR_MAX     = 5'd24;
    localparam logic [BAR_W-1:0]   BAR_RESET   = 5'd24;

    // register index, taken from paddr[2]
    localparam logic REG_SAMPLE_RATE = 1'b0;
    localparam logic REG_BAR_LENGTH  = 1'b1;

    // log2(1 + k/16) in Q16
    localparam logic [16:0] LOG2_TAB [0:16] = '{
        17'd0,     17'd5732,  17'd11136, 17'd16248, 17'd21098, 17'd25711,
        17'd30109, 17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472,
        17'd52911, 17'd56229, 17'd59434, 17'd62534, 17'd65536
    };

endpackage
`default_nettype wire

// File: hw/rtl/spmd_level.sv
// Peak to meter level: log2 by table and interpolation, then dB scaling.
// Four-stage pipeline. Depends on spmd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spmd_level (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [spmd_pkg::PEAK_W-1:0] peak,
    output logic                             done,
    output logic [spmd_pkg::LEVEL_W-1:0]     level
);
    import spmd_pkg::*;

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic        low1_reg, low2_reg, low3_reg;
    logic        full1_reg, full2_reg, full3_reg;
    logic [3:0]  e1_reg, e2_reg;
    logic [3:0]  k1_reg;
    logic [11:0] r1_reg;
    logic [16:0] frac2_reg;
    logic [32:0] prod3_reg;
    logic [LEVEL_W-1:0] level_reg;

    // stage 0: normalise
    logic [15:0] p16;
    logic [3:0]  e0;
    logic [15:0] norm0;
    always_comb
    begin
        p16 = peak[15:0];
        e0  = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (p16[i])
            begin
                e0 = 4'(i);
            end
        end
        norm0 = p16 << (4'd15 - e0);
    end

    // stage 1: table lookup and interpolation
    logic [16:0] t0, t1;
    logic [12:0] dif;
    logic [24:0] ip;
    logic [16:0] frac1;
    always_comb
    begin
        t0    = LOG2_TAB[{1'b0, k1_reg}];
        t1    = LOG2_TAB[5'({1'b0, k1_reg}) + 5'd1];
        dif   = 13'(t1 - t0);
        ip    = dif * r1_reg;
        frac1 = t0 + 17'(ip >> 12);
    end

    // stage 2: distance below 2^16 times log10(2)/2
    logic [20:0] lq2, m2;
    always_comb
    begin
        lq2 = {1'b0, e2_reg, 16'd0} + 21'(frac2_reg);
        m2  = 21'd1048576 - lq2;
    end

    // stage 3: round and clamp
    logic [33:0] rnd3;
    logic [16:0] sub3;
    logic [LEVEL_W-1:0] lvl3;
    always_comb
    begin
        rnd3 = 34'(prod3_reg) + 34'd32768;
        sub3 = 17'(rnd3 >> 16);
        if (low3_reg)
            lvl3 = '0;
        else if (full3_reg)
            lvl3 = LEVEL_MAX;
        else if (sub3[16])
            lvl3 = '0;
        else if (sub3 == '0)
            lvl3 = LEVEL_MAX;
        else
            lvl3 = 16'(17'd65536 - sub3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        low1_reg  <= (peak <= FLOOR_PEAK);
        full1_reg <= (peak >= FULL_SCALE);
        e1_reg    <= e0;
        k1_reg    <= norm0[14:11];
        r1_reg    <= {norm0[10:0], 1'b0};

        low2_reg  <= low1_reg;
        full2_reg <= full1_reg;
        e2_reg    <= e1_reg;
        frac2_reg <= frac1;

        low3_reg  <= low2_reg;
        full3_reg <= full2_reg;
        prod3_reg <= 19'(m2) * LOG_COEF;

        level_reg <= lvl3;
    end

    assign done  = v4_reg;
    assign level = level_reg;

endmodule
`default_nettype wire

// File: hw/rtl/stereo_peak_meter_with_decay_core.sv
// Stereo peak meter top level: sample ring memory, window walk, smoothing, bar output.
// Depends on spmd_pkg, spmd_level and the assertion macro header.
//
//  channel  | handshake                | word
//  ---------+--------------------------+----------------------------------------
//  item     | item_valid / item_stall  | kind, sample_left, sample_right
//  result   | result_valid / result_st.| level_left/right, clip_left/right
//  config   | APB psel/penable/pready  | sample_rate @0x0, bar_length @0x4
//
// A sample word is written to the ring as it is taken; samples stream at one per
// clock while no tick is worked on. A tick reads every second one of the newest
// min(window, fill) samples, one ring read per clock on the single read port, then
// the four-stage level pipe. A result still waiting from the last tick holds the new
// one in the bar stage. The window is sample_rate/20.
// No clearing pass after reset: the walk never reaches past the fill count.
// While a tick is worked on, item_stall is high; a waiting result does not block samples.
`timescale 1ns / 1ps
`default_nettype none
`include "stereo_peak_meter_with_decay_core_macros.svh"
module stereo_peak_meter_with_decay_core #(
    parameter int RING_DEPTH = spmd_pkg::DEF_RING_DEPTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // item channel
    input  wire logic                          item_valid,
    output logic                               item_stall,
    input  wire logic                          kind,
    input  wire logic signed [spmd_pkg::SAMPLE_W-1:0] sample_left,
    input  wire logic signed [spmd_pkg::SAMPLE_W-1:0] sample_right,
    // result channel
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic [spmd_pkg::BAR_W-1:0]         level_left,
    output logic [spmd_pkg::BAR_W-1:0]         level_right,
    output logic                               clip_left,
    output logic                               clip_right,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [spmd_pkg::APB_AW-1:0]   paddr,
    input  wire logic [spmd_pkg::APB_DW-1:0]   pwdata,
    output logic [spmd_pkg::APB_DW-1:0]        prdata,
    output logic                               pready
);
    import spmd_pkg::*;

    localparam int AW    = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int CMP_W = (CNT_W > WIN_W) ? CNT_W : WIN_W;
    localparam logic [AW-1:0]    LAST_ADDR = AW'(RING_DEPTH - 1);
    localparam logic [AW-1:0]    WRAP_STEP = AW'(RING_DEPTH - 2);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(RING_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WIN,
        S_CNT,
        S_WALK,
        S_DRAIN,
        S_LEVEL,
        S_BAR
    } state_t;

    state_t state_reg;

    logic [SR_W-1:0]    sample_rate_reg;
    logic [BAR_W-1:0]   bar_length_reg;
    logic [AW-1:0]      wr_pos_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [WIN_W-1:0]   window_reg;
    logic [WIN_W-1:0]   rem_reg;
    logic [AW-1:0]      addr_reg;
    logic               rd_vld_reg;
    logic [PEAK_W-1:0]  peak_l_reg, peak_r_reg;
    logic [LEVEL_W-1:0] smooth_l_reg, smooth_r_reg;
    logic [HOLD_W-1:0]  hold_l_reg, hold_r_reg;
    logic               result_valid_reg;
    logic [BAR_W-1:0]   level_l_reg, level_r_reg;
    logic               clip_l_reg, clip_r_reg;

    // ring memory, left in the upper half of the word
    logic [2*SAMPLE_W-1:0] ring_mem [RING_DEPTH];
    logic [2*SAMPLE_W-1:0] rd_data_reg;

    logic item_take, sample_wr, tick_take, rd_en, cfg_wr;
    assign item_take = item_valid && !item_stall;
    assign sample_wr = item_take && !kind;
    assign tick_take = item_take && kind;
    assign rd_en     = (state_reg == S_WALK);
    assign cfg_wr    = psel && penable && pwrite && pready;

    always_ff @(posedge clk)
    begin
        if (sample_wr)
        begin
            ring_mem[wr_pos_reg] <= {sample_left, sample_right};
        end
        if (rd_en)
        begin
            rd_data_reg <= ring_mem[addr_reg];
        end
    end

    // window length from the sample rate
    logic [SR_W-1:0] sr_eff;
    logic [30:0]     win_prod;
    always_comb
    begin
        sr_eff   = (sample_rate_reg == '0) ? SR_DEFAULT : sample_rate_reg;
        win_prod = sr_eff[SR_W-1:2] * DIV5_MUL;
    end

    // magnitudes of the word read back
    logic [SAMPLE_W-1:0] raw_l, raw_r;
    logic [PEAK_W-1:0]   abs_l, abs_r;
    always_comb
    begin
        raw_l = rd_data_reg[2*SAMPLE_W-1:SAMPLE_W];
        raw_r = rd_data_reg[SAMPLE_W-1:0];
        abs_l = raw_l[SAMPLE_W-1] ? PEAK_W'(~raw_l + 1'b1) : PEAK_W'(raw_l);
        abs_r = raw_r[SAMPLE_W-1] ? PEAK_W'(~raw_r + 1'b1) : PEAK_W'(raw_r);
    end

    // level pipes, one per channel
    logic               lvl_start;
    logic               lvl_done_l, lvl_done_r;
    logic [LEVEL_W-1:0] lvl_l, lvl_r;
    assign lvl_start = (state_reg == S_DRAIN) && !rd_vld_reg;

    spmd_level u_level_l (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lvl_start),
        .peak  (peak_l_reg),
        .done  (lvl_done_l),
        .level (lvl_l)
    );

    spmd_level u_level_r (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lvl_start),
        .peak  (peak_r_reg),
        .done  (lvl_done_r),
        .level (lvl_r)
    );

    // smoothing and hold
    logic [LEVEL_W-1:0] smooth_l_next, smooth_r_next;
    logic [HOLD_W-1:0]  hold_l_next, hold_r_next;
    always_comb
    begin
        if (lvl_l > smooth_l_reg)
            smooth_l_next = lvl_l;
        else if (smooth_l_reg >= DECAY_Q16)
            smooth_l_next = smooth_l_reg - DECAY_Q16;
        else
            smooth_l_next = '0;

        if (lvl_r > smooth_r_reg)
            smooth_r_next = lvl_r;
        else if (smooth_r_reg >= DECAY_Q16)
            smooth_r_next = smooth_r_reg - DECAY_Q16;
        else
            smooth_r_next = '0;

        if (peak_l_reg > FULL_SCALE)
            hold_l_next = HOLD_FRAMES;
        else if (hold_l_reg != '0)
            hold_l_next = hold_l_reg - 1'b1;
        else
            hold_l_next = '0;

        if (peak_r_reg > FULL_SCALE)
            hold_r_next = HOLD_FRAMES;
        else if (hold_r_reg != '0)
            hold_r_next = hold_r_reg - 1'b1;
        else
            hold_r_next = '0;
    end

    // bar scaling
    logic [BAR_W-1:0]         bar_n;
    logic [LEVEL_W+BAR_W-1:0] bar_l_prod, bar_r_prod;
    logic [BAR_W-1:0]         bar_l, bar_r;
    always_comb
    begin
        if (bar_length_reg < BAR_MIN)
            bar_n = BAR_MIN;
        else if (bar_length_reg > BAR_MAX)
            bar_n = BAR_MAX;
        else
            bar_n = bar_length_reg;
        bar_l_prod = smooth_l_reg * bar_n;
        bar_r_prod = smooth_r_reg * bar_n;
        bar_l = (smooth_l_reg == LEVEL_MAX) ? bar_n : bar_l_prod[LEVEL_W+BAR_W-1:LEVEL_W];
        bar_r = (smooth_r_reg == LEVEL_MAX) ? bar_n : bar_r_prod[LEVEL_W+BAR_W-1:LEVEL_W];
    end

    logic out_free;
    assign out_free = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            sample_rate_reg  <= SR_DEFAULT;
            bar_length_reg   <= BAR_RESET;
            wr_pos_reg       <= '0;
            cnt_reg          <= '0;
            window_reg       <= '0;
            rem_reg          <= '0;
            addr_reg         <= '0;
            rd_vld_reg       <= 1'b0;
            peak_l_reg       <= '0;
            peak_r_reg       <= '0;
            smooth_l_reg     <= '0;
            smooth_r_reg     <= '0;
            hold_l_reg       <= '0;
            hold_r_reg       <= '0;
            result_valid_reg <= 1'b0;
            level_l_reg      <= '0;
            level_r_reg      <= '0;
            clip_l_reg       <= 1'b0;
            clip_r_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (paddr[2])
                    REG_SAMPLE_RATE: sample_rate_reg <= pwdata[SR_W-1:0];
                    REG_BAR_LENGTH:  bar_length_reg  <= pwdata[BAR_W-1:0];
                    default:         ;
                endcase
            end

            // in the bar stage the output register is reloaded instead
            if (result_valid_reg && !result_stall && state_reg != S_BAR)
            begin
                result_valid_reg <= 1'b0;
            end

            if (sample_wr)
            begin
                wr_pos_reg <= (wr_pos_reg == LAST_ADDR) ? '0 : wr_pos_reg + 1'b1;
                if (cnt_reg != FULL_CNT)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end

            rd_vld_reg <= rd_en;
            if (rd_vld_reg)
            begin
                if (abs_l > peak_l_reg)
                    peak_l_reg <= abs_l;
                if (abs_r > peak_r_reg)
                    peak_r_reg <= abs_r;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (tick_take)
                    begin
                        peak_l_reg <= '0;
                        peak_r_reg <= '0;
                        addr_reg   <= (wr_pos_reg == '0) ? LAST_ADDR : wr_pos_reg - 1'b1;
                        state_reg  <= S_WIN;
                    end
                end
                S_WIN:
                begin
                    window_reg <= WIN_W'(win_prod >> DIV5_SHIFT);
                    state_reg  <= S_CNT;
                end
                S_CNT:
                begin
                    // the walk stops at the oldest word written
                    if (CMP_W'(cnt_reg) >= CMP_W'(window_reg))
                    begin
                        rem_reg   <= window_reg;
                        state_reg <= (window_reg == '0) ? S_DRAIN : S_WALK;
                    end
                    else
                    begin
                        rem_reg   <= WIN_W'(cnt_reg);
                        state_reg <= (cnt_reg == '0) ? S_DRAIN : S_WALK;
                    end
                end
                S_WALK:
                begin
                    addr_reg <= (addr_reg >= AW'(2)) ? addr_reg - AW'(2)
                                                     : addr_reg + WRAP_STEP;
                    if (rem_reg <= WIN_W'(2))
                    begin
                        rem_reg   <= '0;
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        rem_reg <= rem_reg - WIN_W'(2);
                    end
                end
                S_DRAIN:
                begin
                    if (!rd_vld_reg)
                    begin
                        state_reg <= S_LEVEL;
                    end
                end
                S_LEVEL:
                begin
                    if (lvl_done_l)
                    begin
                        smooth_l_reg <= smooth_l_next;
                        smooth_r_reg <= smooth_r_next;
                        hold_l_reg   <= hold_l_next;
                        hold_r_reg   <= hold_r_next;
                        state_reg    <= S_BAR;
                    end
                end
                S_BAR:
                begin
                    if (out_free)
                    begin
                        level_l_reg      <= bar_l;
                        level_r_reg      <= bar_r;
                        clip_l_reg       <= (hold_l_reg != '0);
                        clip_r_reg       <= (hold_r_reg != '0);
                        result_valid_reg <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_SAMPLE_RATE: prdata = APB_DW'(sample_rate_reg);
            REG_BAR_LENGTH:  prdata = APB_DW'(bar_length_reg);
            default:         prdata = '0;
        endcase
    end

    assign pready       = 1'b1;
    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign level_left   = level_l_reg;
    assign level_right  = level_r_reg;
    assign clip_left    = clip_l_reg;
    assign clip_right   = clip_r_reg;

    `SPMD_ASSERT(a_walk_bounded, rd_en, rem_reg != '0)
    `SPMD_ASSERT(a_fill_saturates, 1'b1, cnt_reg <= FULL_CNT)
    `SPMD_ASSERT(a_lanes_aligned, 1'b1, lvl_done_l == lvl_done_r)
    `SPMD_ASSERT_NEXT(a_tick_starts_walk, tick_take, state_reg == S_WIN)
    `SPMD_ASSERT(a_bar_in_range, result_valid, level_left <= bar_n && level_right <= bar_n)

endmodule
`default_nettype wire

// File: test/peak_meter_tb_pkg.sv
`timescale 1ns / 1ps
// Word kind codes shared by the peak meter testbench top and its checker.
// No dependencies.
package peak_meter_tb_pkg;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_TICK   = 1'b1
    } word_kind_e;

endpackage

// File: test/peak_meter_checker.sv
`timescale 1ns / 1ps
// Checker for the stereo peak meter: mirrors the sample history and config,
// predicts each frame tick's bar reading and compares it with the result channel.
// Depends on spmd_pkg and peak_meter_tb_pkg.
module peak_meter_checker #(
    parameter int RING_DEPTH = spmd_pkg::DEF_RING_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    input  logic                                item_stall,
    input  logic                                kind,
    input  logic [spmd_pkg::SAMPLE_W-1:0]       sample_left,
    input  logic [spmd_pkg::SAMPLE_W-1:0]       sample_right,
    input  logic                                result_valid,
    input  logic                                result_stall,
    input  logic [spmd_pkg::BAR_W-1:0]          level_left,
    input  logic [spmd_pkg::BAR_W-1:0]          level_right,
    input  logic                                clip_left,
    input  logic                                clip_right,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [spmd_pkg::APB_AW-1:0]         paddr,
    input  logic [spmd_pkg::APB_DW-1:0]         pwdata,
    input  logic                                pready,
    output int                                  errors,
    output int                                  pending,
    output int                                  checked
);
    import spmd_pkg::*;
    import peak_meter_tb_pkg::*;

    typedef struct packed {
        logic [BAR_W-1:0] level_l;
        logic [BAR_W-1:0] level_r;
        logic             clip_l;
        logic             clip_r;
    } bar_reading_t;

    logic [SAMPLE_W-1:0] hist_l [RING_DEPTH];
    logic [SAMPLE_W-1:0] hist_r [RING_DEPTH];
    int unsigned         wr_ptr;
    int unsigned         fill;
    int unsigned         smooth_l, smooth_r;
    int unsigned         hold_l, hold_r;
    int unsigned         rate_reg, bar_reg;
    bar_reading_t        expected_bars [$];
    int                  fail_count;
    int                  match_count;
    int                  queued;

    assign errors  = fail_count;
    assign pending = queued;
    assign checked = match_count;

    function automatic int unsigned magnitude(logic [SAMPLE_W-1:0] v);
        int unsigned u;
        u = 32'(v);
        return v[SAMPLE_W-1] ? 32'h40000 - u : u;
    endfunction

    // log2 via msb position plus interpolated table fraction, then dB mapping
    function automatic int unsigned level_of_peak(int unsigned p);
        int unsigned      e, mant, seg, rem, fr, gap_q16;
        longint unsigned  wide;
        if (p <= FLOOR_PEAK)
            return 0;
        if (p >= FULL_SCALE)
            return 32'(LEVEL_MAX);
        e = 0;
        while ((p >> (e + 1)) != 0)
            e++;
        mant = (p << (16 - e)) - 32'd65536;
        seg  = (mant >> 12) & 15;
        rem  = mant & 4095;
        fr   = LOG2_TAB[seg] + (((LOG2_TAB[seg + 1] - LOG2_TAB[seg]) * rem) >> 12);
        gap_q16 = (32'd16 << 16) - ((e << 16) + fr);
        wide = 64'(gap_q16);
        wide = (wide * LOG_COEF + 64'd32768) >> 16;
        if (wide >= 64'd65536)
            return 0;
        wide = 64'd65536 - wide;
        return (wide > LEVEL_MAX) ? 32'(LEVEL_MAX) : 32'(wide);
    endfunction

    function automatic int unsigned decay_step(int unsigned s, int unsigned lvl);
        if (lvl > s)
            return lvl;
        return (s >= DECAY_Q16) ? s - DECAY_Q16 : 0;
    endfunction

    function automatic int unsigned next_hold(int unsigned h, int unsigned pk);
        if (pk > FULL_SCALE)
            return 32'(HOLD_FRAMES);
        return (h > 0) ? h - 1 : 0;
    endfunction

    function automatic int unsigned segments(int unsigned s, int unsigned n);
        if (s >= LEVEL_MAX)
            return n;
        return (s * n) >> 16;
    endfunction

    // walks every second stored sample, newest first, and advances meter state
    function automatic bar_reading_t predict_bars();
        int unsigned  rate, span, pk_l, pk_r, idx, i, n;
        bar_reading_t r;
        rate = (rate_reg == 0) ? 32'(SR_DEFAULT) : rate_reg;
        span = rate * 50 / 1000;
        pk_l = 0;
        pk_r = 0;
        for (i = 0; i < span && i < fill; i += 2) begin
            idx = (wr_ptr + RING_DEPTH - 1 - i) % RING_DEPTH;
            if (magnitude(hist_l[idx]) > pk_l)
                pk_l = magnitude(hist_l[idx]);
            if (magnitude(hist_r[idx]) > pk_r)
                pk_r = magnitude(hist_r[idx]);
        end
        hold_l   = next_hold(hold_l, pk_l);
        hold_r   = next_hold(hold_r, pk_r);
        smooth_l = decay_step(smooth_l, level_of_peak(pk_l));
        smooth_r = decay_step(smooth_r, level_of_peak(pk_r));
        n = bar_reg;
        if (n < BAR_MIN)
            n = 32'(BAR_MIN);
        if (n > BAR_MAX)
            n = 32'(BAR_MAX);
        r.level_l = BAR_W'(segments(smooth_l, n));
        r.level_r = BAR_W'(segments(smooth_r, n));
        r.clip_l  = (hold_l > 0);
        r.clip_r  = (hold_r > 0);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [BAR_W-1:0] want,
                               input logic [BAR_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    initial begin
        fail_count  = 0;
        match_count = 0;
        queued      = 0;
    end

    always @(posedge clk) begin
        bar_reading_t got;
        bar_reading_t want;
        if (!rst_n) begin
            wr_ptr   = 0;
            fill     = 0;
            smooth_l = 0;
            smooth_r = 0;
            hold_l   = 0;
            hold_r   = 0;
            rate_reg = 32'(SR_DEFAULT);
            bar_reg  = 32'(BAR_RESET);
            expected_bars.delete();
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_BAR_LENGTH)
                    bar_reg = 32'(pwdata[BAR_W-1:0]);
                else
                    rate_reg = 32'(pwdata[SR_W-1:0]);
            end
            // results first: a tick taken at this edge cannot have answered yet
            if (result_valid && !result_stall) begin
                got = {level_left, level_right, clip_left, clip_right};
                if (expected_bars.size() == 0) begin
                    $display("%0t: bar reading expected none actual %h", $time, got);
                    fail_count++;
                end
                else begin
                    want = expected_bars.pop_front();
                    check_field("level_left", want.level_l, got.level_l);
                    check_field("level_right", want.level_r, got.level_r);
                    check_field("clip_left", want.clip_l, got.clip_l);
                    check_field("clip_right", want.clip_r, got.clip_r);
                    match_count++;
                end
            end
            if (item_valid && !item_stall) begin
                if (kind == KIND_TICK)
                    expected_bars.push_back(predict_bars());
                else begin
                    hist_l[wr_ptr] = sample_left;
                    hist_r[wr_ptr] = sample_right;
                    wr_ptr = (wr_ptr + 1) % RING_DEPTH;
                    if (fill < RING_DEPTH)
                        fill++;
                end
            end
        end
        queued <= expected_bars.size();
    end

endmodule

// File: test/tb_stereo_peak_meter_with_decay_core.sv
`timescale 1ns / 1ps
// Testbench top for the stereo peak meter: clock, reset, word and config stimulus.
// Depends on spmd_pkg, peak_meter_tb_pkg, peak_meter_checker and the core.
module tb_stereo_peak_meter_with_decay_core;
    import spmd_pkg::*;
    import peak_meter_tb_pkg::*;

    localparam logic [APB_AW-1:0] ADDR_RATE = {REG_SAMPLE_RATE, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_BARS = {REG_BAR_LENGTH, 2'b00};
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASES         = 8;
    localparam int PHASE_WORDS    = 40;
    localparam int LONG_RUN       = 30;
    localparam int FIXED_PHASES   = 6;
    localparam int PHASE_RATE [FIXED_PHASES] = '{0, 19, 400, 44100, 1000, 96000};
    localparam int PHASE_BARS [FIXED_PHASES] = '{3, 31, 5, 0, 24, 12};
    localparam int DIRECTED   = 11;
    localparam int DIR_LEFT  [DIRECTED] = '{131071, 65536, 65537, -65537, 655, 656,
                                           -1000, 30000, -32768, 4096, -131072};
    localparam int DIR_RIGHT [DIRECTED] = '{-131072, -65536, -65537, 65536, -656, 655,
                                           1000, -4095, 32767, 65535, 131071};

    logic                       clk;
    logic                       rst_n;
    logic                       item_valid;
    logic                       item_stall;
    logic                       kind;
    logic signed [SAMPLE_W-1:0] sample_left;
    logic signed [SAMPLE_W-1:0] sample_right;
    logic                       result_valid;
    logic                       result_stall;
    logic [BAR_W-1:0]           level_left;
    logic [BAR_W-1:0]           level_right;
    logic                       clip_left;
    logic                       clip_right;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [APB_AW-1:0]          paddr;
    logic [APB_DW-1:0]          pwdata;
    logic [APB_DW-1:0]          prdata;
    logic                       pready;

    int errors, pending, checked;
    int quiet_cycles;
    int samples_sent, ticks_sent, settings;
    bit steady;

    stereo_peak_meter_with_decay_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .kind         (kind),
        .sample_left  (sample_left),
        .sample_right (sample_right),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .level_left   (level_left),
        .level_right  (level_right),
        .clip_left    (clip_left),
        .clip_right   (clip_right),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    peak_meter_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .kind         (kind),
        .sample_left  (sample_left),
        .sample_right (sample_right),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .level_left   (level_left),
        .level_right  (level_right),
        .clip_left    (clip_left),
        .clip_right   (clip_right),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .errors       (errors),
        .pending      (pending),
        .checked      (checked)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk) begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
                || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_stereo_peak_meter_with_decay_core: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic int draw_gap();
        if (steady)
            return 0;
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
    endfunction

    // 0 quiet, 1 moderate, 2 around full scale, 3 any 18-bit pattern
    function automatic logic signed [SAMPLE_W-1:0] draw_sample(int cls);
        int mag;
        case (cls)
            0:       mag = $urandom_range(0, 700);
            1:       mag = $urandom_range(0, 20000);
            2:       mag = $urandom_range(60000, 70000);
            default: return SAMPLE_W'($urandom());
        endcase
        return ($urandom_range(0, 1) == 1) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
    endfunction

    task automatic send_word(input word_kind_e k, input logic signed [SAMPLE_W-1:0] l,
                             input logic signed [SAMPLE_W-1:0] r);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid   <= 1'b1;
        kind         <= k;
        sample_left  <= l;
        sample_right <= r;
        do @(posedge clk); while (!(item_valid && !item_stall));
        if (k == KIND_TICK)
            ticks_sent++;
        else
            samples_sent++;
    endtask

    task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // block idle: every reading back, plus slack for a sample write in flight
    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic configure(input int rate, input int bars);
        write_reg(ADDR_RATE, rate);
        write_reg(ADDR_BARS, bars);
        settings++;
    endtask

    // result side: stall counted only in cycles where a word is on offer
    initial begin : bar_sink
        int hold;
        result_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            hold = draw_gap();
            if (hold > 0) begin
                result_stall <= 1'b1;
                while (hold > 0) begin
                    @(posedge clk);
                    if (result_valid)
                        hold--;
                end
                result_stall <= 1'b0;
            end
            do @(posedge clk); while (!(result_valid && !result_stall));
        end
    end

    initial begin : stimulus
        int p, words, ticks, run, cls, i;
        item_valid   <= 1'b0;
        kind         <= KIND_SAMPLE;
        sample_left  <= '0;
        sample_right <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        rst_n        <= 1'b0;
        steady       = 1'b0;
        samples_sent = 0;
        ticks_sent   = 0;
        settings     = 1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // tick before any sample at reset config, fields at their extremes
        send_word(KIND_TICK, SAMPLE_W'(131071), SAMPLE_W'(-131072));
        settle();
        // window of one sample so each tick sees only the newest word
        configure(20, 24);
        for (i = 0; i < DIRECTED; i++) begin
            send_word(KIND_SAMPLE, SAMPLE_W'(DIR_LEFT[i]), SAMPLE_W'(DIR_RIGHT[i]));
            send_word(KIND_TICK, SAMPLE_W'($urandom()), SAMPLE_W'($urandom()));
        end
        settle();

        for (p = 0; p < PHASES; p++) begin
            if (p < FIXED_PHASES)
                configure(PHASE_RATE[p], PHASE_BARS[p]);
            else
                configure($urandom_range(20, 96000), $urandom_range(0, 31));
            steady = (p % 3 == 2);
            words = 0;
            ticks = 0;
            while (words < PHASE_WORDS || ticks < 6) begin
                run = ($urandom_range(0, 15) == 0) ? $urandom_range(50, 150)
                                                   : $urandom_range(0, 6);
                cls = $urandom_range(0, 3);
                repeat (run) send_word(KIND_SAMPLE, draw_sample(cls), draw_sample(cls));
                send_word(KIND_TICK, SAMPLE_W'($urandom()), SAMPLE_W'($urandom()));
                words += run + 1;
                ticks++;
            end
            settle();
        end

        // highest rate: the window reaches past the stored history
        configure(96000, 24);
        steady = 1'b1;
        cls = 1;
        for (i = 0; i < LONG_RUN; i++) begin
            if (i % 8 == 0)
                cls = $urandom_range(0, 3);
            send_word(KIND_SAMPLE, draw_sample(cls), draw_sample(cls));
        end
        steady = 1'b0;
        repeat (8) begin
            cls = $urandom_range(0, 3);
            repeat ($urandom_range(0, 6))
                send_word(KIND_SAMPLE, draw_sample(cls), draw_sample(cls));
            send_word(KIND_TICK, SAMPLE_W'($urandom()), SAMPLE_W'($urandom()));
        end

        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (32) @(posedge clk);

        $display("Covered %0d sample words and %0d frame ticks over %0d register settings,",
                 samples_sent, ticks_sent, settings);
        $display("including windows longer than the history; %0d bar readings compared.",
                 checked);
        if (errors == 0 && pending == 0)
            $display("tb_stereo_peak_meter_with_decay_core: clean");
        else
            $display("tb_stereo_peak_meter_with_decay_core: errors");
        $finish;
    end

endmodule
